// ===== rtl/ntpf_pkg.sv =====
// Shared types, constants and the CRC byte step for the numbered test packet framer.
`timescale 1ns / 1ps

package ntpf_pkg;

  localparam int SeqW       = 32;
  localparam int ByteW      = 8;
  localparam int PosW       = 6;
  localparam int HdrBytes   = 4;
  localparam int PayloadMax = 58;
  localparam int QDepth     = 2;
  localparam int QAddrW     = 1;
  localparam int QCntW      = 2;
  localparam int OutDataW   = 16;

  localparam logic [ByteW-1:0] PayloadMark = 8'hA0;
  localparam logic [15:0]      CrcInit     = 16'hFFFF;
  localparam logic [15:0]      CrcPoly     = 16'h1021;

  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [ByteW-1:0] key;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic [PosW-1:0]  byte_position;
    logic             frame_last;
  } beat_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [ByteW-1:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/numbered_test_packet_framer_top.sv =====
// Usage:
// Slave stream takes one 32-bit sequence number per transfer. The master stream
// returns its test frame one byte per transfer: four big-endian header bytes,
// PAYLOAD_BYTES payload bytes (capped at 58), then the CRC16 high and low bytes.
// tlast marks the CRC low byte; tdata carries the byte and its frame position.
// A frame's number passes input register, queue, sequencer and output register.
// Throughput: one byte per cycle while the receiver does not stall; a frame
// holds PAYLOAD_BYTES + 6 bytes (38 at the default); frames follow with no gap
// if the next number waits: the sequencer loads it as it drives the last byte.
// The rate is set by the single byte sequencer and its output register.
// Up to three numbers wait ahead of the running frame (input register plus a
// two-entry queue); s_axis_tready drops when they are full.
// Reset clears all valid flags and the queue; any frame in flight is lost.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits, then the queue fills and input is back-pressured.
`timescale 1ns / 1ps

module numbered_test_packet_framer_top
  import ntpf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SeqW-1:0]     s_axis_tdata,   // [31:0] seq_number
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_position, [15:14] 0
  output logic                m_axis_tlast    // frame_last
);

  logic  push, q_ready, pop, q_valid;
  item_t push_item, q_head;
  beat_t beat;

  ntpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_seq_i    (s_axis_tdata),
    .push_o      (push),
    .q_ready_i   (q_ready),
    .push_item_o (push_item)
  );

  ntpf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ntpf_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (beat)
  );

  assign m_axis_tdata = {{(OutDataW-ByteW-PosW){1'b0}}, beat.byte_position, beat.frame_byte};
  assign m_axis_tlast = beat.frame_last;

endmodule

// ===== rtl/ntpf_front.sv =====
// Input stage: registers a sequence number and derives its payload key.
`timescale 1ns / 1ps

module ntpf_front
  import ntpf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SeqW-1:0] in_seq_i,
  output logic            push_o,
  input  logic            q_ready_i,
  output item_t           push_item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  always_comb begin
    push_o     = valid_q && q_ready_i;
    in_ready_o = !valid_q || q_ready_i;
    valid_d    = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.seq <= in_seq_i;
      item_q.key <= in_seq_i[ByteW-1:0] ^ PayloadMark;
    end
  end

  assign push_item_o = item_q;

endmodule

// ===== rtl/ntpf_fifo.sv =====
// Two-entry queue between the input stage and the frame sequencer.
`timescale 1ns / 1ps

module ntpf_fifo
  import ntpf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  item_t             mem_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign ready_o = cnt_q != QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/ntpf_back.sv =====
// Frame sequencer: walks header, payload and CRC bytes into an output register.
`timescale 1ns / 1ps

module ntpf_back
  import ntpf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output beat_t out_beat_o
);

  localparam int PLen = (PAYLOAD_BYTES > PayloadMax) ? PayloadMax : PAYLOAD_BYTES;
  localparam logic [PosW-1:0] HdrEnd    = PosW'(HdrBytes);
  localparam logic [PosW-1:0] CrcHiPos  = PosW'(PLen + HdrBytes);
  localparam logic [PosW-1:0] LastPos   = PosW'(PLen + HdrBytes + 1);

  logic             busy_q, busy_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [SeqW-1:0]  seq_q;
  logic [ByteW-1:0] key_q;
  logic [15:0]      crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  beat_t            beat_q, beat_d;

  logic             advance, load, is_hdr, is_pay, is_hi, is_last;
  logic [PosW-1:0]  pay_idx;
  logic [ByteW-1:0] hdr_byte, cur_byte;

  always_comb begin
    advance = !out_valid_q || out_ready_i;
    is_hdr  = pos_q < HdrEnd;
    is_pay  = !is_hdr && (pos_q < CrcHiPos);
    is_hi   = pos_q == CrcHiPos;
    is_last = pos_q == LastPos;
    load    = advance && (!busy_q || is_last);
    pop_o   = load && q_valid_i;
    pay_idx = pos_q - HdrEnd;

    case (pos_q[1:0])
      2'd0:    hdr_byte = seq_q[31:24];
      2'd1:    hdr_byte = seq_q[23:16];
      2'd2:    hdr_byte = seq_q[15:8];
      default: hdr_byte = seq_q[7:0];
    endcase

    if (is_hdr) begin
      cur_byte = hdr_byte;
    end else if (is_pay) begin
      cur_byte = key_q ^ {{(ByteW-PosW){1'b0}}, pay_idx};
    end else if (is_hi) begin
      cur_byte = crc_q[15:8];
    end else begin
      cur_byte = crc_q[7:0];
    end

    busy_d      = busy_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    beat_d      = beat_q;

    if (advance) begin
      out_valid_d          = busy_q;
      beat_d.frame_byte    = cur_byte;
      beat_d.byte_position = pos_q;
      beat_d.frame_last    = is_last;
      if (load) begin
        busy_d = q_valid_i;
        pos_d  = '0;
        crc_d  = CrcInit;
      end else begin
        pos_d = pos_q + 1'b1;
        if (is_hdr || is_pay) begin
          crc_d = crc_feed(crc_q, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    beat_q <= beat_d;
    if (pop_o) begin
      seq_q <= q_head_i.seq;
      key_q <= q_head_i.key;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = beat_q;

endmodule

// ===== rtl/ntpf_checker.sv =====
// Port-level checks for the numbered test packet framer, bound to the top level.
`timescale 1ns / 1ps

module ntpf_checker
  import ntpf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  localparam int PLen = (PAYLOAD_BYTES > PayloadMax) ? PayloadMax : PAYLOAD_BYTES;
  localparam logic [PosW-1:0] LastPos = PosW'(PLen + HdrBytes + 1);

  logic [PosW-1:0] pos;
  assign pos = m_axis_tdata[ByteW+PosW-1:ByteW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (pos == LastPos)))
    else $error("tlast not on final frame position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pos <= LastPos)
    else $error("frame position out of range");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (pos == $past(pos) + 1'b1))
    else $error("gap or skip inside a frame");

endmodule

bind numbered_test_packet_framer_top ntpf_checker #(
  .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_ntpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the numbered test packet framer: CRC framing, byte order and tlast.
`timescale 1ns / 1ps

module testbench;
  import ntpf_pkg::*;

  localparam int PAYLOAD_BYTES = 32;
  localparam int PAY_COUNT     = (PAYLOAD_BYTES > PayloadMax) ? PayloadMax : PAYLOAD_BYTES;
  localparam int IDLE_LIMIT    = 1000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_STALL_RUN = 16;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SeqW-1:0]     s_axis_tdata;    // [31:0] seq_number
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;    // [7:0] frame_byte, [13:8] byte_position, [15:14] 0
  logic                m_axis_tlast;    // frame_last

  beat_t    pending_bytes [$];
  beat_t    want;
  int       errors;
  int       idle_cycles;
  int       burst_left;
  bit       gaps_on;
  rx_mode_e rx_mode;
  int       rx_mode_left;
  int       rx_stall_run;
  bit       rx_next;

  numbered_test_packet_framer_top #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [ByteW-1:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic void queue_byte(logic [ByteW-1:0] b, int pos, logic last);
    beat_t beat;
    beat.frame_byte    = b;
    beat.byte_position = pos[PosW-1:0];
    beat.frame_last    = last;
    pending_bytes.push_back(beat);
  endfunction

  function automatic void predict_frame(logic [SeqW-1:0] seq);
    logic [15:0]      crc;
    logic [ByteW-1:0] b;
    int               pos;
    crc = CrcInit;
    pos = 0;
    for (int i = 0; i < HdrBytes; i++) begin
      b   = ByteW'(seq >> (8 * (HdrBytes - 1 - i)));
      crc = ccitt_next(crc, b);
      queue_byte(b, pos, 1'b0);
      pos++;
    end
    for (int p = 0; p < PAY_COUNT; p++) begin
      b   = PayloadMark ^ ByteW'(p) ^ seq[ByteW-1:0];
      crc = ccitt_next(crc, b);
      queue_byte(b, pos, 1'b0);
      pos++;
    end
    queue_byte(crc[15:8], pos, 1'b0);
    queue_byte(crc[7:0], pos + 1, 1'b1);
  endfunction

  task automatic send_seq_number(input logic [SeqW-1:0] seq);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seq;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(seq);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
    errors++;
    $display("%0t %s: expected %h, actual %h", $time, what, exp_v, act_v);
  endtask

  task automatic test_header_extremes();
    gaps_on = 1'b0;
    send_seq_number(32'h0000_0000);
    send_seq_number(32'hFFFF_FFFF);
    send_seq_number(32'h0000_0001);
    send_seq_number(32'h8000_0000);
    send_seq_number(32'hAAAA_AAAA);
    send_seq_number(32'h5555_5555);
    send_seq_number(32'hFF00_0000);
    send_seq_number(32'h0000_00FF);
    send_seq_number(32'h0102_0304);
    send_seq_number(32'h1234_5678);
  endtask

  task automatic test_payload_mixing();
    gaps_on    = 1'b1;
    burst_left = 0;
    send_seq_number(32'h0000_00A0);
    send_seq_number(32'h0000_005F);
    send_seq_number(32'h0000_0080);
    send_seq_number(32'hFFFF_FF7F);
    send_seq_number(32'hDEAD_BEEF);
    send_seq_number(32'h00FF_00A0);
  endtask

  task automatic test_random_back_to_back();
    gaps_on = 1'b0;
    repeat (60) send_seq_number($urandom());
  endtask

  task automatic test_random_bursts();
    gaps_on    = 1'b1;
    burst_left = 0;
    repeat (160) send_seq_number($urandom());
  endtask

  task automatic drain_frames();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN:   rx_next = 1'b1;
      RX_LIGHT:  rx_next = ($urandom_range(0, 3) != 0);
      RX_HEAVY:  rx_next = ($urandom_range(0, 3) == 0);
      default:   rx_next = !m_axis_tready;
    endcase
    if (rx_stall_run >= MAX_STALL_RUN) rx_next = 1'b1;
    rx_stall_run = rx_next ? 0 : rx_stall_run + 1;
    m_axis_tready <= rx_next;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected transfer", 16'h0000, m_axis_tdata);
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata[ByteW-1:0] !== want.frame_byte)
          report_mismatch("frame_byte", 16'(want.frame_byte), 16'(m_axis_tdata[ByteW-1:0]));
        if (m_axis_tdata[ByteW+PosW-1:ByteW] !== want.byte_position)
          report_mismatch("byte_position", 16'(want.byte_position),
                          16'(m_axis_tdata[ByteW+PosW-1:ByteW]));
        if (m_axis_tdata[OutDataW-1:ByteW+PosW] !== '0)
          report_mismatch("tdata pad", 16'h0000, 16'(m_axis_tdata[OutDataW-1:ByteW+PosW]));
        if (m_axis_tlast !== want.frame_last)
          report_mismatch("frame_last", 16'(want.frame_last), 16'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    errors        = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    rx_mode       = RX_OPEN;
    rx_mode_left  = 0;
    rx_stall_run  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_header_extremes();
    test_payload_mixing();
    test_random_back_to_back();
    test_random_bursts();
    drain_frames();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ntpf_pkg.sv
rtl/ntpf_front.sv
rtl/ntpf_fifo.sv
rtl/ntpf_back.sv
rtl/numbered_test_packet_framer_top.sv
rtl/ntpf_checker.sv
sim/testbench.sv
